// ===== rtl/core/compacting_value_list_defines.svh =====
// Assertion macros for the compacting value list.
`ifndef COMPACTING_VALUE_LIST_DEFINES_SVH
`define COMPACTING_VALUE_LIST_DEFINES_SVH

`ifndef ASSERT_OFF
`define CVL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CVL_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CVL_ASSERT(label, clk, rst_n, prop, msg)
`define CVL_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/core/cvl_pkg.sv =====
// Types, codes and microprogram of the compacting value list.
package cvl_pkg;

    localparam int CVL_DEPTH = 8;
    localparam int OP_W      = 2;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 6;
    localparam int FILL_W    = 7;
    localparam int MDATA_W   = 48;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_DELETE,
        OP_DUMP,
        OP_NONE
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_EMPTY,
        ST_NOTFOUND
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_CHK,
        S_APP_WR,
        S_APP_FULL,
        S_DEL_CHK,
        S_DEL_CMP,
        S_DEL_NEXT,
        S_DEL_MISS,
        S_DEL_EMPTY,
        S_SHF_RD,
        S_SHF_WR,
        S_DEL_DONE,
        S_DMP_CHK,
        S_DMP_OUT,
        S_DMP_EMPTY
    } t_step;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_DISPATCH,
        C_FULL,
        C_EMPTY,
        C_MATCH,
        C_MORE
    } t_cond;

    typedef enum logic { RA_IDX, RA_IDX_INC } t_rasel;
    typedef enum logic { WA_COUNT, WA_IDX } t_wasel;
    typedef enum logic { WD_VAL, WD_RDATA } t_wdsel;
    typedef enum logic [1:0] { P_ZERO, P_IDX, P_COUNT, P_POS } t_psel;
    typedef enum logic [1:0] { V_IN, V_MEM, V_ZERO } t_vsel;
    typedef enum logic [1:0] { CNT_HOLD, CNT_INC, CNT_DEC } t_cntop;

    typedef struct packed {
        t_cond   cond;
        t_step   tgt_t;
        t_step   tgt_f;
        logic    ld_in;
        logic    clr_idx;
        logic    inc_idx;
        logic    save_pos;
        logic    rd;
        t_rasel  ra;
        logic    wr;
        t_wasel  wa;
        t_wdsel  wd;
        logic    emit;
        t_status st;
        t_psel   ps;
        t_vsel   vs;
        logic    last_auto;
        t_cntop  cnt;
    } t_cword;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic full;
        logic empty;
        logic match;
        logic more;
    } t_flags;

    function automatic t_step dispatch(input t_op op);
        t_step s;
        case (op)
            OP_APPEND: s = S_APP_CHK;
            OP_DELETE: s = S_DEL_CHK;
            OP_DUMP:   s = S_DMP_CHK;
            default:   s = S_IDLE;
        endcase
        return s;
    endfunction

    // One control word per step.
    function automatic t_cword ucode(input t_step s);
        t_cword cw;
        cw = '0;
        cw.tgt_t = S_IDLE;
        cw.tgt_f = S_IDLE;
        case (s)
            S_IDLE: begin
                cw.cond    = C_DISPATCH;
                cw.ld_in   = 1'b1;
                cw.clr_idx = 1'b1;
            end
            S_APP_CHK: begin
                cw.cond  = C_FULL;
                cw.tgt_t = S_APP_FULL;
                cw.tgt_f = S_APP_WR;
            end
            S_APP_WR: begin
                cw.wr   = 1'b1;
                cw.wa   = WA_COUNT;
                cw.wd   = WD_VAL;
                cw.cnt  = CNT_INC;
                cw.emit = 1'b1;
                cw.st   = ST_OK;
                cw.ps   = P_COUNT;
                cw.vs   = V_IN;
            end
            S_APP_FULL: begin
                cw.emit = 1'b1;
                cw.st   = ST_FULL;
                cw.ps   = P_ZERO;
                cw.vs   = V_IN;
            end
            S_DEL_CHK: begin
                cw.cond  = C_EMPTY;
                cw.tgt_t = S_DEL_EMPTY;
                cw.tgt_f = S_DEL_CMP;
                cw.rd    = 1'b1;
                cw.ra    = RA_IDX;
            end
            S_DEL_CMP: begin
                cw.cond     = C_MATCH;
                cw.tgt_t    = S_SHF_RD;
                cw.tgt_f    = S_DEL_NEXT;
                cw.save_pos = 1'b1;
            end
            S_DEL_NEXT: begin
                cw.cond    = C_MORE;
                cw.tgt_t   = S_DEL_CMP;
                cw.tgt_f   = S_DEL_MISS;
                cw.inc_idx = 1'b1;
                cw.rd      = 1'b1;
                cw.ra      = RA_IDX_INC;
            end
            S_DEL_MISS: begin
                cw.emit = 1'b1;
                cw.st   = ST_NOTFOUND;
                cw.ps   = P_ZERO;
                cw.vs   = V_IN;
            end
            S_DEL_EMPTY: begin
                cw.emit = 1'b1;
                cw.st   = ST_EMPTY;
                cw.ps   = P_ZERO;
                cw.vs   = V_IN;
            end
            S_SHF_RD: begin
                cw.cond  = C_MORE;
                cw.tgt_t = S_SHF_WR;
                cw.tgt_f = S_DEL_DONE;
                cw.rd    = 1'b1;
                cw.ra    = RA_IDX_INC;
            end
            S_SHF_WR: begin
                cw.tgt_t   = S_SHF_RD;
                cw.wr      = 1'b1;
                cw.wa      = WA_IDX;
                cw.wd      = WD_RDATA;
                cw.inc_idx = 1'b1;
            end
            S_DEL_DONE: begin
                cw.cnt  = CNT_DEC;
                cw.emit = 1'b1;
                cw.st   = ST_OK;
                cw.ps   = P_POS;
                cw.vs   = V_IN;
            end
            S_DMP_CHK: begin
                cw.cond  = C_EMPTY;
                cw.tgt_t = S_DMP_EMPTY;
                cw.tgt_f = S_DMP_OUT;
                cw.rd    = 1'b1;
                cw.ra    = RA_IDX;
            end
            S_DMP_OUT: begin
                cw.cond      = C_MORE;
                cw.tgt_t     = S_DMP_OUT;
                cw.tgt_f     = S_IDLE;
                cw.inc_idx   = 1'b1;
                cw.rd        = 1'b1;
                cw.ra        = RA_IDX_INC;
                cw.emit      = 1'b1;
                cw.st        = ST_OK;
                cw.ps        = P_IDX;
                cw.vs        = V_MEM;
                cw.last_auto = 1'b1;
            end
            S_DMP_EMPTY: begin
                cw.emit = 1'b1;
                cw.st   = ST_EMPTY;
                cw.ps   = P_ZERO;
                cw.vs   = V_ZERO;
            end
            default: begin
                cw.cond = C_ALWAYS;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/core/cvl_sequencer.sv =====
// Step counter and microcode lookup of the compacting value list.
`include "compacting_value_list_defines.svh"

module cvl_sequencer import cvl_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_flags          i_flags,
    input  logic [OP_W-1:0] i_op,
    output t_cword          o_cw,
    output logic            o_exec
);

    t_step  r_step;
    t_step  n_step;
    t_cword w_cw;
    logic   w_exec;
    logic   w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        w_cw   = ucode(r_step);
        // hold the step while waiting on either handshake
        w_exec = !(w_cw.ld_in && !i_flags.in_valid) && !(w_cw.emit && !i_flags.out_free);
        w_take = 1'b0;
        case (w_cw.cond)
            C_ALWAYS: w_take = 1'b1;
            C_FULL:   w_take = i_flags.full;
            C_EMPTY:  w_take = i_flags.empty;
            C_MATCH:  w_take = i_flags.match;
            C_MORE:   w_take = i_flags.more;
            default:  w_take = 1'b0;
        endcase
        n_step = r_step;
        if (w_exec) begin
            if (w_cw.cond == C_DISPATCH) begin
                n_step = dispatch(t_op'(i_op));
            end else begin
                n_step = w_take ? w_cw.tgt_t : w_cw.tgt_f;
            end
        end
        o_cw   = w_cw;
        o_exec = w_exec;
    end

    `CVL_ASSERT(a_leave_idle, i_clk, i_rst_n, (w_exec && w_cw.ld_in && (t_op'(i_op) != OP_NONE)) |=> (r_step != S_IDLE), "accepted item did not start a program")
    `CVL_ASSERT_NEVER(a_emit_needs_room, i_clk, i_rst_n, w_exec && w_cw.emit && !i_flags.out_free, "result emitted into a busy output register")
    `CVL_ASSERT(a_hold_on_stall, i_clk, i_rst_n, !w_exec |=> $stable(r_step), "step advanced while stalled")

endmodule

// ===== rtl/core/cvl_datapath.sv =====
// Entry memory, index and count registers, and output register of the list.
`include "compacting_value_list_defines.svh"

module cvl_datapath import cvl_pkg::*; #(
    parameter int DEPTH = CVL_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cword             i_cw,
    input  logic               i_exec,
    input  logic               i_s_tvalid,
    input  logic [VAL_W-1:0]   i_s_tdata,
    input  logic               i_m_tready,
    output t_flags             o_flags,
    output logic               o_m_tvalid,
    output t_status            o_m_status,
    output logic [POS_W-1:0]   o_m_pos,
    output logic [VAL_W-1:0]   o_m_val,
    output logic [FILL_W-1:0]  o_m_fill,
    output logic               o_m_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [VAL_W-1:0] r_mem [DEPTH];

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     n_idx;
    logic [AW-1:0]     r_pos;
    logic [VAL_W-1:0]  r_val;
    logic [VAL_W-1:0]  r_rdata;
    logic              r_mvalid;
    logic              n_mvalid;
    t_status           r_mstatus;
    logic [POS_W-1:0]  r_mpos;
    logic [POS_W-1:0]  n_mpos;
    logic [VAL_W-1:0]  r_mval;
    logic [VAL_W-1:0]  n_mval;
    logic [FILL_W-1:0] r_mfill;
    logic              r_mlast;

    logic [CW-1:0]     w_idx_next;
    logic              w_more;
    logic [AW-1:0]     w_raddr;
    logic [AW-1:0]     w_waddr;
    logic [VAL_W-1:0]  w_wdata;
    logic              w_load;

    always_comb begin
        w_idx_next = CW'(r_idx) + CW'(1);
        w_more     = w_idx_next < r_count;
        w_raddr    = (i_cw.ra == RA_IDX_INC) ? (r_idx + AW'(1)) : r_idx;
        w_waddr    = (i_cw.wa == WA_COUNT) ? r_count[AW-1:0] : r_idx;
        w_wdata    = (i_cw.wd == WD_VAL) ? r_val : r_rdata;
        w_load     = i_exec && i_cw.emit;

        case (i_cw.cnt)
            CNT_INC: n_count = r_count + CW'(1);
            CNT_DEC: n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
        if (!i_exec) begin
            n_count = r_count;
        end

        n_idx = r_idx;
        if (i_exec && i_cw.clr_idx) begin
            n_idx = '0;
        end else if (i_exec && i_cw.inc_idx) begin
            n_idx = r_idx + AW'(1);
        end

        case (i_cw.ps)
            P_IDX:   n_mpos = POS_W'(r_idx);
            P_COUNT: n_mpos = POS_W'(r_count);
            P_POS:   n_mpos = POS_W'(r_pos);
            default: n_mpos = '0;
        endcase

        case (i_cw.vs)
            V_IN:    n_mval = r_val;
            V_MEM:   n_mval = r_rdata;
            default: n_mval = '0;
        endcase

        // a held result drains while the next one is being prepared
        if (w_load) begin
            n_mvalid = 1'b1;
        end else if (i_m_tready) begin
            n_mvalid = 1'b0;
        end else begin
            n_mvalid = r_mvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_mvalid <= n_mvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_exec && i_cw.ld_in) begin
            r_val <= i_s_tdata;
        end
        if (i_exec && i_cw.save_pos) begin
            r_pos <= r_idx;
        end
        if (w_load) begin
            r_mstatus <= i_cw.st;
            r_mpos    <= n_mpos;
            r_mval    <= n_mval;
            r_mfill   <= FILL_W'(n_count);
            r_mlast   <= i_cw.last_auto ? !w_more : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_exec && i_cw.wr) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_exec && i_cw.rd) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    assign o_flags.in_valid = i_s_tvalid;
    assign o_flags.out_free = !r_mvalid || i_m_tready;
    assign o_flags.full     = (r_count == CW'(DEPTH));
    assign o_flags.empty    = (r_count == '0);
    assign o_flags.match    = (r_rdata == r_val);
    assign o_flags.more     = w_more;

    assign o_m_tvalid = r_mvalid;
    assign o_m_status = r_mstatus;
    assign o_m_pos    = r_mpos;
    assign o_m_val    = r_mval;
    assign o_m_fill   = r_mfill;
    assign o_m_last   = r_mlast;

    `CVL_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(DEPTH), "entry count above depth")
    `CVL_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, w_load && r_mvalid && !i_m_tready, "held result overwritten")
    `CVL_ASSERT_NEVER(a_wr_in_range, i_clk, i_rst_n, i_exec && i_cw.wr && (CW'(w_waddr) > r_count), "write beyond list end")

endmodule

// ===== rtl/core/compacting_value_list.sv =====
// Top level of the compacting value list: microcoded sequencer and datapath.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: op, tdata: value
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser: status, tdata: position,
//                                              entry_value, fill_count; tlast
//
//  One item at a time; the input is taken in the idle step. Append: check room,
//  then write at the count and emit. Delete: compare entries in order through the
//  single memory read port, then shift each later entry down by a read and a write.
//  Dump: one result per entry, one result per cycle while the output register has room.
//  A result waits in the output register; a step that emits holds while it is full.
//  Reset clears the count and control; entry storage is not cleared.
module compacting_value_list import cvl_pkg::*; #(
    parameter int DEPTH = CVL_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VAL_W-1:0]   s_axis_tdata,   // [31:0] value
    input  logic [OP_W-1:0]    s_axis_tuser,   // [1:0] op
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [MDATA_W-1:0] m_axis_tdata,   // [5:0] position, [37:6] entry_value,
                                               // [44:38] fill_count, [47:45] zero
    output logic [1:0]         m_axis_tuser,   // [1:0] status
    output logic               m_axis_tlast
);

    t_cword           w_cw;
    logic             w_exec;
    t_flags           w_flags;
    t_status          w_status;
    logic [POS_W-1:0] w_pos;
    logic [VAL_W-1:0] w_val;
    logic [FILL_W-1:0] w_fill;

    cvl_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .i_op    (s_axis_tuser),
        .o_cw    (w_cw),
        .o_exec  (w_exec)
    );

    cvl_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cw       (w_cw),
        .i_exec     (w_exec),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tdata  (s_axis_tdata),
        .i_m_tready (m_axis_tready),
        .o_flags    (w_flags),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_status (w_status),
        .o_m_pos    (w_pos),
        .o_m_val    (w_val),
        .o_m_fill   (w_fill),
        .o_m_last   (m_axis_tlast)
    );

    assign s_axis_tready = w_cw.ld_in;
    assign m_axis_tuser  = w_status;
    assign m_axis_tdata  = {(MDATA_W - FILL_W - VAL_W - POS_W)'(0), w_fill, w_val, w_pos};

endmodule
